@@ rtl/core/cf2d_pkg.sv @@
// ----------------------------------------------------------------------------
// cf2d_pkg
// Shared constants and types for the 2D Coulomb force pipeline.
// ----------------------------------------------------------------------------
package cf2d_pkg;

    // Direction cosine precision and the widths of the per-axis units.
    localparam int DIR_BITS    = 16;
    localparam int RATIO_STEPS = 2 * DIR_BITS + 1;
    localparam int RQ_W        = 2 * DIR_BITS + 2;
    localparam int ROOT_W      = DIR_BITS + 1;
    localparam int SREM_W      = DIR_BITS + 4;
    localparam int SQRT_STEPS  = RQ_W / 2;

    // Fixed field widths.
    localparam int K_W   = 32;
    localparam int CHG_W = 16;
    localparam int M_W   = K_W + 2 * CHG_W - 2;
    localparam int OUT_W = 32;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_K   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN = 1'b1;

    // Sign bits that travel beside the data: charge product and both deltas.
    typedef struct packed {
        logic       pneg;
        logic [1:0] dneg;
    } t_sign;

endpackage

@@ rtl/core/cf2d_prep.sv @@
// ----------------------------------------------------------------------------
// cf2d_prep
// Front stages: deltas and charge product, squares and k*|p|, clamped r^2.
// ----------------------------------------------------------------------------
module cf2d_prep
    import cf2d_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int RW         = 34
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_sx,
    input  logic signed [COORD_BITS-1:0] i_sy,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic signed [CHG_W-1:0]      i_q1,
    input  logic signed [CHG_W-1:0]      i_q2,
    input  logic [K_W-1:0]               i_k,
    input  logic [K_W-1:0]               i_min,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [RW-1:0]                o_den,
    output logic [M_W-1:0]               o_m,
    output logic [RW-1:0]                o_a [2],
    output t_sign                        o_sign
);

    localparam int C   = COORD_BITS;
    localparam int SQW = 2 * C + 2;
    localparam int PW  = 2 * CHG_W;

    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;

    logic signed [C:0]    r1_dx, r1_dy;
    logic signed [PW-1:0] r1_p;
    logic [SQW-1:0]       r2_sq [2];
    logic [M_W-1:0]       r2_m;
    t_sign                r2_sign;
    logic [RW-1:0]        r3_den;
    logic [M_W-1:0]       r3_m;
    logic [RW-1:0]        r3_a [2];
    t_sign                r3_sign;

    logic [C:0]       w_adx, w_ady;
    logic [PW-2:0]    w_ap;
    logic [RW-1:0]    w_sum, w_clamp;

    // Ready ripples back through the three stages.
    assign w_rdy3  = ~r_v3 | i_ready;
    assign w_rdy2  = ~r_v2 | w_rdy3;
    assign w_rdy1  = ~r_v1 | w_rdy2;
    assign o_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // Stage one: coordinate deltas and the raw charge product.
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_dx <= $signed({i_sx[C-1], i_sx}) - $signed({i_bx[C-1], i_bx});
            r1_dy <= $signed({i_sy[C-1], i_sy}) - $signed({i_by[C-1], i_by});
            r1_p  <= i_q1 * i_q2;
        end
    end

    // Stage two: squared deltas and the scaled charge magnitude.
    assign w_adx = r1_dx[C] ? (~r1_dx + 1'b1) : r1_dx;
    assign w_ady = r1_dy[C] ? (~r1_dy + 1'b1) : r1_dy;
    assign w_ap  = r1_p[PW-1] ? (PW-1)'(~r1_p + 1'b1) : (PW-1)'(r1_p);

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_sq[0]     <= SQW'(w_adx) * SQW'(w_adx);
            r2_sq[1]     <= SQW'(w_ady) * SQW'(w_ady);
            r2_m         <= M_W'(i_k) * M_W'(w_ap);
            r2_sign.pneg <= r1_p[PW-1];
            r2_sign.dneg <= {r1_dy[C], r1_dx[C]};
        end
    end

    // Stage three: r^2 clamped from below by the minimum and by one.
    assign w_sum = RW'(r2_sq[0]) + RW'(r2_sq[1]);

    always_comb begin
        w_clamp = (w_sum < RW'(i_min)) ? RW'(i_min) : w_sum;
        if (w_clamp == '0) w_clamp = RW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r3_den  <= w_clamp;
            r3_m    <= r2_m;
            r3_a[0] <= RW'(r2_sq[0]);
            r3_a[1] <= RW'(r2_sq[1]);
            r3_sign <= r2_sign;
        end
    end

    assign o_valid = r_v3;
    assign o_den   = r3_den;
    assign o_m     = r3_m;
    assign o_a     = r3_a;
    assign o_sign  = r3_sign;

endmodule

@@ rtl/core/cf2d_cell.sv @@
// ----------------------------------------------------------------------------
// cf2d_cell
// One cell of the chain: a quotient bit of k*|p|/r^2, and per axis a bit of
// the ratio d^2/r^2 or a bit of its square root, or neither, depending on position.
// ----------------------------------------------------------------------------
module cf2d_cell
    import cf2d_pkg::*;
#(
    parameter int RW   = 34,
    parameter int STEP = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [RW-1:0]     i_den,
    input  logic [RW-1:0]     i_rem,
    input  logic [M_W-1:0]    i_nq,
    input  logic [RW-1:0]     i_rrem [2],
    input  logic [RQ_W-1:0]   i_rq   [2],
    input  logic [SREM_W-1:0] i_srem [2],
    input  logic [ROOT_W-1:0] i_root [2],
    input  t_sign             i_sign,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [RW-1:0]     o_den,
    output logic [RW-1:0]     o_rem,
    output logic [M_W-1:0]    o_nq,
    output logic [RW-1:0]     o_rrem [2],
    output logic [RQ_W-1:0]   o_rq   [2],
    output logic [SREM_W-1:0] o_srem [2],
    output logic [ROOT_W-1:0] o_root [2],
    output t_sign             o_sign
);

    localparam bit DO_RATIO = (STEP < RATIO_STEPS);
    localparam bit DO_SQRT  = (STEP >= RATIO_STEPS) && (STEP < RATIO_STEPS + SQRT_STEPS);

    logic r_valid;
    logic [RW-1:0]     r_den, r_rem;
    logic [M_W-1:0]    r_nq;
    logic [RW-1:0]     r_rrem [2];
    logic [RQ_W-1:0]   r_rq   [2];
    logic [SREM_W-1:0] r_srem [2];
    logic [ROOT_W-1:0] r_root [2];
    t_sign             r_sign;

    logic [RW-1:0]     n_rem;
    logic [M_W-1:0]    n_nq;
    logic [RW-1:0]     n_rrem [2];
    logic [RQ_W-1:0]   n_rq   [2];
    logic [SREM_W-1:0] n_srem [2];
    logic [ROOT_W-1:0] n_root [2];

    logic [RW:0] w_mrem;
    logic        w_mge;

    assign o_ready = ~r_valid | i_ready;

    // Restoring division step on the force magnitude.
    assign w_mrem = {i_rem, i_nq[M_W-1]};
    assign w_mge  = (w_mrem >= {1'b0, i_den});
    assign n_rem  = w_mge ? RW'(w_mrem - {1'b0, i_den}) : RW'(w_mrem);
    assign n_nq   = {i_nq[M_W-2:0], w_mge};

    // Per axis: ratio division step, square root step, or hold.
    always_comb begin
        logic [RW:0]     v_r2;
        logic            v_rge;
        logic [SREM_W-1:0] v_s2;
        logic [SREM_W-1:0] v_trial;
        logic            v_sge;
        for (int a = 0; a < 2; a++) begin
            v_r2    = '0;
            v_rge   = 1'b0;
            v_s2    = '0;
            v_trial = '0;
            v_sge   = 1'b0;
            n_rrem[a] = i_rrem[a];
            n_rq[a]   = i_rq[a];
            n_srem[a] = i_srem[a];
            n_root[a] = i_root[a];
            if (DO_RATIO) begin
                // The first step takes the integer bit, the rest shift in zeros.
                v_r2  = (STEP == 0) ? {1'b0, i_rrem[a]} : {i_rrem[a], 1'b0};
                v_rge = (v_r2 >= {1'b0, i_den});
                n_rrem[a] = v_rge ? RW'(v_r2 - {1'b0, i_den}) : RW'(v_r2);
                n_rq[a]   = {i_rq[a][RQ_W-2:0], v_rge};
            end else if (DO_SQRT) begin
                v_s2    = {i_srem[a][SREM_W-3:0], i_rq[a][RQ_W-1:RQ_W-2]};
                v_trial = SREM_W'({i_root[a], 2'b01});
                v_sge   = (v_s2 >= v_trial);
                n_srem[a] = v_sge ? (v_s2 - v_trial) : v_s2;
                n_root[a] = {i_root[a][ROOT_W-2:0], v_sge};
                n_rq[a]   = {i_rq[a][RQ_W-3:0], 2'b00};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_den  <= i_den;
            r_rem  <= n_rem;
            r_nq   <= n_nq;
            r_rrem <= n_rrem;
            r_rq   <= n_rq;
            r_srem <= n_srem;
            r_root <= n_root;
            r_sign <= i_sign;
        end
    end

    assign o_valid = r_valid;
    assign o_den   = r_den;
    assign o_rem   = r_rem;
    assign o_nq    = r_nq;
    assign o_rrem  = r_rrem;
    assign o_rq    = r_rq;
    assign o_srem  = r_srem;
    assign o_root  = r_root;
    assign o_sign  = r_sign;

endmodule

@@ rtl/core/cf2d_post.sv @@
// ----------------------------------------------------------------------------
// cf2d_post
// Back stages: magnitude times direction cosine, then sign, saturation and
// the output register.
// ----------------------------------------------------------------------------
module cf2d_post
    import cf2d_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [M_W-1:0]    i_quo,
    input  logic [ROOT_W-1:0] i_cos [2],
    input  t_sign             i_sign,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [OUT_W-1:0]  o_force [2],
    output logic              o_sat
);

    localparam int TQW  = M_W - 32 + FRAC_BITS;
    localparam int PRW  = TQW + ROOT_W;
    localparam int MAGW = PRW - DIR_BITS;
    localparam logic [MAGW-1:0] LIM_NEG = MAGW'(64'h8000_0000);
    localparam logic [MAGW-1:0] LIM_POS = MAGW'(64'h7FFF_FFFF);

    logic r_v1, r_v2, w_rdy1, w_rdy2;
    logic [MAGW-1:0]  r_mag [2];
    t_sign            r_sign;
    logic [OUT_W-1:0] r_force [2];
    logic             r_sat;
    logic [TQW-1:0]   w_tq;
    logic [PRW-1:0]   w_prod [2];
    logic [OUT_W-1:0] n_force [2];
    logic             n_sat;

    assign w_rdy2  = ~r_v2 | i_ready;
    assign w_rdy1  = ~r_v1 | w_rdy2;
    assign o_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
        end
    end

    // Drop the extra fraction bits, then scale by each direction cosine.
    assign w_tq      = i_quo[M_W-1 -: TQW];
    assign w_prod[0] = PRW'(w_tq) * PRW'(i_cos[0]);
    assign w_prod[1] = PRW'(w_tq) * PRW'(i_cos[1]);

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_mag[0] <= w_prod[0][PRW-1:DIR_BITS];
            r_mag[1] <= w_prod[1][PRW-1:DIR_BITS];
            r_sign   <= i_sign;
        end
    end

    // Apply the sign and clip each component to 32 signed bits.
    always_comb begin
        logic            v_neg;
        logic [MAGW-1:0] v_clip;
        n_sat = 1'b0;
        for (int a = 0; a < 2; a++) begin
            v_neg  = r_sign.pneg ^ r_sign.dneg[a];
            v_clip = r_mag[a];
            if (v_neg && (r_mag[a] > LIM_NEG)) begin
                v_clip = LIM_NEG;
                n_sat  = 1'b1;
            end else if (!v_neg && (r_mag[a] > LIM_POS)) begin
                v_clip = LIM_POS;
                n_sat  = 1'b1;
            end
            n_force[a] = v_neg ? (~v_clip[OUT_W-1:0] + 1'b1) : v_clip[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_force <= n_force;
            r_sat   <= n_sat;
        end
    end

    assign o_valid = r_v2;
    assign o_force = r_force;
    assign o_sat   = r_sat;

endmodule

@@ rtl/core/coulomb_force_2d_top.sv @@
// ----------------------------------------------------------------------------
// coulomb_force_2d_top
// Pairwise 2D Coulomb force with fixed point inputs and saturated output.
//
//  Channel   Direction  Contents
//  s_axis    in         tdata: source_x, source_y, body_x, body_y,
//                       source_charge, body_charge
//  m_axis    out        tdata: force_x, force_y; tuser: saturated
//  i_cfg_*   in         register writes: 0 coupling_constant, 1 min_dist_sq
//
// One item per cycle is sustained while the output is not stalled. At the default
// parameters there are three front stages, one cell per quotient bit of k*|p|/r^2
// (62 cells, which also run the ratio and square root units) and two back
// stages. Each stage holds its item while the next one is full, so a
// stalled output fills the chain before the input stalls. Reset is
// synchronous and active low; it clears valid bits and loads the register
// defaults.
// ----------------------------------------------------------------------------
module coulomb_force_2d_top
    import cf2d_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [K_W-1:0]       i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // source_x, source_y, body_x, body_y, source_charge, body_charge
    input  logic [((4*COORD_BITS+2*CHG_W+7)/8)*8-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // force_x, force_y
    output logic [2*OUT_W-1:0]   m_axis_tdata,
    // saturated
    output logic                 m_axis_tuser
);

    localparam int C     = COORD_BITS;
    localparam int RW    = (2 * C + 2 > K_W) ? 2 * C + 2 : K_W;
    localparam int NCELL = M_W;

    logic [K_W-1:0] r_k, r_min;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k   <= K_W'(65536);
            r_min <= K_W'(100);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_K:   r_k   <= i_cfg_data;
                CFG_MIN: r_min <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic              w_valid [NCELL+1];
    logic              w_ready [NCELL+1];
    logic [RW-1:0]     w_den   [NCELL+1];
    logic [RW-1:0]     w_rem   [NCELL+1];
    logic [M_W-1:0]    w_nq    [NCELL+1];
    logic [RW-1:0]     w_rrem  [NCELL+1][2];
    logic [RQ_W-1:0]   w_rq    [NCELL+1][2];
    logic [SREM_W-1:0] w_srem  [NCELL+1][2];
    logic [ROOT_W-1:0] w_root  [NCELL+1][2];
    t_sign             w_sign  [NCELL+1];
    logic [OUT_W-1:0]  w_force [2];

    // Front stages.
    cf2d_prep #(
        .COORD_BITS(COORD_BITS),
        .RW        (RW)
    ) u_prep (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready),
        .i_sx   (s_axis_tdata[C-1:0]),
        .i_sy   (s_axis_tdata[2*C-1:C]),
        .i_bx   (s_axis_tdata[3*C-1:2*C]),
        .i_by   (s_axis_tdata[4*C-1:3*C]),
        .i_q1   (s_axis_tdata[4*C+CHG_W-1:4*C]),
        .i_q2   (s_axis_tdata[4*C+2*CHG_W-1:4*C+CHG_W]),
        .i_k    (r_k),
        .i_min  (r_min),
        .o_valid(w_valid[0]),
        .i_ready(w_ready[0]),
        .o_den  (w_den[0]),
        .o_m    (w_nq[0]),
        .o_a    (w_rrem[0]),
        .o_sign (w_sign[0])
    );

    // The division and square root units start from zero.
    assign w_rem[0]     = '0;
    assign w_rq[0][0]   = '0;
    assign w_rq[0][1]   = '0;
    assign w_srem[0][0] = '0;
    assign w_srem[0][1] = '0;
    assign w_root[0][0] = '0;
    assign w_root[0][1] = '0;

    // Chain of cells, one quotient bit each.
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        cf2d_cell #(
            .RW  (RW),
            .STEP(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(w_valid[g]),
            .o_ready(w_ready[g]),
            .i_den  (w_den[g]),
            .i_rem  (w_rem[g]),
            .i_nq   (w_nq[g]),
            .i_rrem (w_rrem[g]),
            .i_rq   (w_rq[g]),
            .i_srem (w_srem[g]),
            .i_root (w_root[g]),
            .i_sign (w_sign[g]),
            .o_valid(w_valid[g+1]),
            .i_ready(w_ready[g+1]),
            .o_den  (w_den[g+1]),
            .o_rem  (w_rem[g+1]),
            .o_nq   (w_nq[g+1]),
            .o_rrem (w_rrem[g+1]),
            .o_rq   (w_rq[g+1]),
            .o_srem (w_srem[g+1]),
            .o_root (w_root[g+1]),
            .o_sign (w_sign[g+1])
        );
    end

    // Back stages and output register.
    cf2d_post #(
        .FRAC_BITS(FRAC_BITS)
    ) u_post (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_valid[NCELL]),
        .o_ready(w_ready[NCELL]),
        .i_quo  (w_nq[NCELL]),
        .i_cos  (w_root[NCELL]),
        .i_sign (w_sign[NCELL]),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_force(w_force),
        .o_sat  (m_axis_tuser)
    );

    assign m_axis_tdata = {w_force[1], w_force[0]};

endmodule

@@ tb/force_checker.sv @@
// ----------------------------------------------------------------------------
// force_checker
// Watches the input and output streams of the Coulomb force block, predicts
// each force item from the accepted input item and compares field by field.
// ----------------------------------------------------------------------------
module force_checker
    import cf2d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [K_W-1:0]    i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [95:0]       i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [63:0]       i_out_data,
    input  logic              i_out_user,
    output int                o_errors,
    output int                o_pending,
    output int                o_seen,
    output int                o_sat_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] fx;
        logic [31:0] fy;
        logic        sat;
    } force_t;

    force_t      force_q[$];
    logic [31:0] coupling;
    logic [31:0] min_sq;

    // Bitwise integer square root of a 64-bit value.
    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res, bit_v;
        res = 0;
        bit_v = 64'h1 << 62;
        while (bit_v > x) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (x >= res + bit_v) begin
                x = x - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // One axis: direction cosine, magnitude, sign and clipping.
    function automatic logic [31:0] axis_value(input logic signed [63:0] d,
                                               input logic [63:0] tq,
                                               input logic [63:0] r2,
                                               input logic pneg,
                                               inout logic sat);
        logic [63:0]  ad, c, mag;
        logic [127:0] ratio;
        ad = (d < 0) ? -d : d;
        ratio = ({64'd0, ad * ad} << 32) / r2;
        c = int_sqrt(ratio[63:0]);
        mag = (tq >> 16) * c + (((tq & 64'hFFFF) * c) >> 16);
        if (mag == 0) return 32'd0;
        if (pneg != (d < 0)) begin
            if (mag > 64'h8000_0000) begin
                mag = 64'h8000_0000;
                sat = 1'b1;
            end
            return 32'(-mag);
        end
        if (mag > 64'h7FFF_FFFF) begin
            mag = 64'h7FFF_FFFF;
            sat = 1'b1;
        end
        return mag[31:0];
    endfunction

    function automatic force_t predict_force(input logic [95:0] din);
        logic signed [63:0] dx, dy, p;
        logic [63:0]  r2, ap, tq;
        logic [127:0] m;
        force_t f;
        logic sat;
        dx = 64'(signed'(din[15:0])) - 64'(signed'(din[47:32]));
        dy = 64'(signed'(din[31:16])) - 64'(signed'(din[63:48]));
        p  = 64'(signed'(din[79:64])) * 64'(signed'(din[95:80]));
        ap = (p < 0) ? -p : p;
        r2 = dx * dx + dy * dy;
        if (r2 < {32'd0, min_sq}) r2 = {32'd0, min_sq};
        if (r2 < 1) r2 = 1;
        m = {96'd0, coupling} * {64'd0, ap};
        tq = 64'((m / r2) >> 16);
        sat = 1'b0;
        f.fx = axis_value(dx, tq, r2, p < 0, sat);
        f.fy = axis_value(dy, tq, r2, p < 0, sat);
        f.sat = sat;
        return f;
    endfunction

    always @(posedge i_clk) begin
        force_t want;
        if (!i_rst_n) begin
            coupling <= 32'd65536;
            min_sq   <= 32'd100;
            o_errors <= 0;
            o_seen <= 0;
            o_sat_seen <= 0;
            o_pending <= 0;
            force_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_K) coupling <= i_cfg_data;
                else if (i_cfg_idx == CFG_MIN) min_sq <= i_cfg_data;
            end
            if (i_in_valid && i_in_ready) force_q.push_back(predict_force(i_in_data));
            if (i_out_valid && i_out_ready) begin
                o_seen <= o_seen + 1;
                if (i_out_user) o_sat_seen <= o_sat_seen + 1;
                if (force_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected force item %h", i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = force_q.pop_front();
                    if (want.fx !== i_out_data[31:0] || want.fy !== i_out_data[63:32]
                        || want.sat !== i_out_user) begin
                        if (o_errors < 10)
                            $display("force mismatch: want x=%h y=%h s=%b got x=%h y=%h s=%b",
                                     want.fx, want.fy, want.sat, i_out_data[31:0],
                                     i_out_data[63:32], i_out_user);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= force_q.size();
        end
    end
endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random position and charge items into the Coulomb
// force block across several register settings, with random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
    import cf2d_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 67;
    localparam int LIMIT   = 400000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_K;
    logic [K_W-1:0]    i_cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [95:0]       s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [63:0]       m_axis_tdata;
    logic              m_axis_tuser;
    int errors, pending, seen, sat_seen, cycles;
    int sent = 0;
    bit stall_on = 1'b1;

    coulomb_force_2d_top dut (.*);

    force_checker u_check (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_user(m_axis_tuser),
        .o_errors(errors), .o_pending(pending), .o_seen(seen), .o_sat_seen(sat_seen)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Cycle limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Receiver: random stalls per item, sometimes none at all.
    initial begin
        int gap;
        forever begin
            gap = stall_on ? $urandom_range(0, 17) : 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    task automatic send_item(input logic [15:0] sx, sy, bx, by, q1, q2, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {q2, q1, by, bx, sy, sx};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_item(input bit gaps);
        logic [15:0] sx, sy, bx, by;
        sx = 16'($urandom);
        sy = 16'($urandom);
        // Mostly nearby bodies so that forces stay in range.
        if ($urandom_range(0, 3) != 0) begin
            bx = sx + 16'($urandom_range(0, 80)) - 16'd40;
            by = sy + 16'($urandom_range(0, 80)) - 16'd40;
        end else begin
            bx = 16'($urandom);
            by = 16'($urandom);
        end
        send_item(sx, sy, bx, by, 16'($urandom), 16'($urandom), gaps);
    endtask

    initial begin
        logic [31:0] k_set[5], m_set[5];
        k_set = '{32'd65536, 32'hFFFF_FFFF, 32'd0, 32'd1000, 32'd300000};
        m_set = '{32'd100, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd5000};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed items at reset settings: extremes, coincident points, zero charge.
        send_item(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        send_item(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
        send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_item(16'd5, 16'd5, 16'd5, 16'd5, 16'h0100, 16'h0100, 1'b0);
        send_item(16'd0, 16'd0, 16'd3, 16'd0, 16'h0000, 16'h7FFF, 1'b0);
        send_item(16'd0, 16'd0, 16'd1, 16'd0, 16'h8000, 16'h8000, 1'b0);
        send_item(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'h8000, 16'h7FFF, 1'b0);
        send_item(16'd10, 16'd0, 16'd0, 16'd10, 16'h0100, 16'hFF00, 1'b0);
        send_item(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
        send_item(16'd100, 16'd0, 16'd0, 16'd0, 16'h0001, 16'h0001, 1'b0);

        // Random phases over register settings; each drains the block before its register writes.
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            write_reg(CFG_K, k_set[ph]);
            write_reg(CFG_MIN, m_set[ph]);
            stall_on = (ph != 3);
            send_item(16'd0, 16'd0, 16'd1, 16'd1, 16'h7FFF, 16'h8000, 1'b1);
            send_item(16'd7, 16'd7, 16'd7, 16'd7, 16'h7FFF, 16'h7FFF, 1'b1);
            for (int i = 0; i < 208; i++) random_item(ph != 3 && (i % 50) < 35);
        end
        drain();

        $display("covered %0d items in 5 register settings; %0d results, %0d saturated",
                 sent, seen, sat_seen);
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
